>>> hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

>>> hdl/bgrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bgrc_pkg;

	// Fixed-point format of the coefficients.
	localparam int COEF_FRAC_BITS = 16;
	localparam int COEF_W = COEF_FRAC_BITS + 2;
	localparam int OP_W = 9;
	localparam int PROD_W = COEF_W + OP_W;
	localparam int SUM_W = PROD_W + 2;
	localparam int QUO_W = SUM_W - COEF_FRAC_BITS;
	localparam int NTERM = 3;
	localparam int NCHAN = 3;

	typedef enum logic {
		DIR_FWD = 1'b0,
		DIR_INV = 1'b1
	} dir_t;

	typedef logic signed [OP_W-1:0] op_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	// Per-stage advance enables handed from the top level to each channel.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

	// Coefficient in thousandths, rounded to nearest with ties up, sign applied.
	function automatic coef_t qc(input int unsigned milli, input logic neg);
		longint unsigned mag;
		mag = ((longint'(milli) << COEF_FRAC_BITS) + 64'd500) / 64'd1000;
		if (neg) begin
			return -coef_t'(mag);
		end
		return coef_t'(mag);
	endfunction

	// Weights by direction, output channel and operand.
	// Forward operands: R, G, B. Inverse operands: Cr - 128, Cb - 128, Y.
	localparam coef_t COEF_TAB [2][NCHAN][NTERM] = '{
		'{
			'{qc(299, 1'b0), qc(587, 1'b0), qc(114, 1'b0)},
			'{qc(169, 1'b1), qc(331, 1'b1), qc(500, 1'b0)},
			'{qc(500, 1'b0), qc(419, 1'b1), qc(81, 1'b1)}
		},
		'{
			'{qc(0, 1'b0), qc(1772, 1'b0), qc(1000, 1'b0)},
			'{qc(714, 1'b1), qc(344, 1'b1), qc(1000, 1'b0)},
			'{qc(1402, 1'b0), qc(0, 1'b0), qc(1000, 1'b0)}
		}
	};

	// Chroma outputs of the forward transform get 128 added after truncation.
	localparam logic ADD_HALF_TAB [2][NCHAN] = '{
		'{1'b0, 1'b1, 1'b1},
		'{1'b0, 1'b0, 1'b0}
	};

endpackage

`default_nettype wire

>>> hdl/bgrc_channel.sv
`timescale 1ns / 1ps
`default_nettype none

module bgrc_channel (
	input  logic                clk,
	input  bgrc_pkg::pipe_en_t  en,
	input  bgrc_pkg::op_t       op_s1 [bgrc_pkg::NTERM],
	input  bgrc_pkg::coef_t     coef_s1 [bgrc_pkg::NTERM],
	input  logic                add_half_s1,
	output logic [7:0]          pix_s4
);
	import bgrc_pkg::*;

	localparam logic signed [SUM_W-1:0] TRUNC_BIAS =
		SUM_W'((longint'(1) << COEF_FRAC_BITS) - 1);
	localparam logic signed [QUO_W:0] HALF = (QUO_W + 1)'(128);
	localparam logic signed [QUO_W:0] PIX_MAX = (QUO_W + 1)'(255);

	logic signed [PROD_W-1:0] prod_s2 [NTERM];
	logic                     add_half_s2;
	logic signed [SUM_W-1:0]  sum_s3;
	logic                     add_half_s3;
	logic signed [SUM_W-1:0]  adj;
	logic signed [QUO_W-1:0]  quo;
	logic signed [QUO_W:0]    val;
	logic [7:0]               pix_nx;

	// Stage 2: one product per term.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int j = 0; j < NTERM; j++) begin
				prod_s2[j] <= op_s1[j] * coef_s1[j];
			end
			add_half_s2 <= add_half_s1;
		end
	end

	// Stage 3: signed sum of the three terms.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			sum_s3 <= SUM_W'(prod_s2[0]) + SUM_W'(prod_s2[1]) + SUM_W'(prod_s2[2]);
			add_half_s3 <= add_half_s2;
		end
	end

	// Truncate toward zero, add the chroma offset and clip to 0..255.
	always_comb begin
		adj = sum_s3[SUM_W-1] ? sum_s3 + TRUNC_BIAS : sum_s3;
		quo = adj[SUM_W-1:COEF_FRAC_BITS];
		val = {quo[QUO_W-1], quo} + (add_half_s3 ? HALF : '0);
		if (val[QUO_W]) begin
			pix_nx = 8'd0;
		end else if (val > PIX_MAX) begin
			pix_nx = 8'd255;
		end else begin
			pix_nx = val[7:0];
		end
	end

	// Stage 4: output register.
	always_ff @(posedge clk) begin
		if (en.s4) begin
			pix_s4 <= pix_nx;
		end
	end

endmodule

`default_nettype wire

>>> hdl/bgr_ycbcr_color_convert.sv
`timescale 1ns / 1ps
`default_nettype none

// Pixel converter between BGR and full-range YCbCr with BT.601 weights.
// Input beat: comp_a, comp_b, comp_c (B, G, R forward; Y, Cb, Cr inverse),
// taken when in_valid is high and in_stall is low.
// Output beat: out_a, out_b, out_c (Y, Cb, Cr forward; B, G, R inverse),
// taken by the receiver when out_valid is high and out_stall is low.
// cfg_we with cfg_wdata selects the direction: 0 forward, 1 inverse.
// Change it only while no beat is in flight.
// An accepted input beat reaches out_valid through four register stages:
// operand select, multiply, sum, truncate and clip. Throughput is one
// pixel per cycle while the receiver does not stall; the multiply stage
// holds nine multipliers, one per product of a pixel.
// Reset clears the valid bit of every stage and sets the direction to forward.
// When the receiver stalls, the output beat holds, empty stages behind it
// keep filling, and in_stall rises once all four stages are occupied.
module bgr_ycbcr_color_convert (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] comp_a,
	input  logic [7:0] comp_b,
	input  logic [7:0] comp_c,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_a,
	output logic [7:0] out_b,
	output logic [7:0] out_c
);
	import bgrc_pkg::*;

	localparam op_t HALF_OP = op_t'(128);

	dir_t     direction_q;
	dir_t     dir_s1;
	logic     v_s1, v_s2, v_s3, v_s4;
	logic     en_s1;
	pipe_en_t en;
	op_t      op_nx [NTERM];
	op_t      op_s1 [NTERM];
	logic [7:0] pix_s4 [NCHAN];

	// Direction register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_FWD;
		end else if (cfg_we) begin
			direction_q <= dir_t'(cfg_wdata);
		end
	end

	// A stage advances when it is empty or the stage after it advances.
	always_comb begin
		en.s4 = !v_s4 || !out_stall;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en_s1 = !v_s1 || en.s2;
	end

	assign in_stall = !en_s1;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en.s2) begin
				v_s2 <= v_s1;
			end
			if (en.s3) begin
				v_s3 <= v_s2;
			end
			if (en.s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Operand select: chroma inputs lose their 128 offset in the inverse case.
	always_comb begin
		op_nx[0] = op_t'({1'b0, comp_c});
		op_nx[1] = op_t'({1'b0, comp_b});
		op_nx[2] = op_t'({1'b0, comp_a});
		if (direction_q == DIR_INV) begin
			op_nx[0] = op_t'({1'b0, comp_c}) - HALF_OP;
			op_nx[1] = op_t'({1'b0, comp_b}) - HALF_OP;
		end
	end

	// Stage 1: operands and the direction that goes with them.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1  <= op_nx;
			dir_s1 <= direction_q;
		end
	end

	// One multiply, sum and clip lane per output component.
	for (genvar ch = 0; ch < NCHAN; ch++) begin : g_chan
		bgrc_channel u_chan (
			.clk         (clk),
			.en          (en),
			.op_s1       (op_s1),
			.coef_s1     (COEF_TAB[dir_s1][ch]),
			.add_half_s1 (ADD_HALF_TAB[dir_s1][ch]),
			.pix_s4      (pix_s4[ch])
		);
	end

	assign out_valid = v_s4;
	assign out_a     = pix_s4[0];
	assign out_b     = pix_s4[1];
	assign out_c     = pix_s4[2];

endmodule

`default_nettype wire

>>> hdl/bgrc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bgrc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_a,
	input logic [7:0] out_b,
	input logic [7:0] out_c
);

	// A stalled output beat stays put.
	`ASSERT_CLK(a_out_hold, clk, arst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_a) && $stable(out_b) && $stable(out_c)), "stalled output beat changed")

	// The input side only stalls when the output is full and stalled.
	`ASSERT_ALWAYS(a_stall_cause, clk, in_stall |-> (out_valid && out_stall), "input stalled without a full pipeline")

	// With out_stall low behind it, an accepted pixel reaches out_valid.
	`ASSERT_CLK(a_latency, clk, arst_n, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid, "accepted pixel did not arrive in four cycles")

	// During reset nothing is offered downstream.
	`ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !out_valid, "output valid during reset")

endmodule

bind bgr_ycbcr_color_convert bgrc_checker u_bgrc_checker (.*);

`default_nettype wire
